/* rtl/core/mtf_pkg.sv */
// mtf_pkg: shared types and constants of the move-to-front codec
// used by mtf_cell, mtf_reduce and move_to_front_codec; no dependencies
package mtf_pkg;

   // width of one symbol or rank word on the ports
   localparam int VALUE_W = 8;
   // width of the alphabet size register
   localparam int SIZE_W = 9;
   // number of cells folded by one node of the first reduction level
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);

   // register indexes of the configuration port
   localparam logic CSR_DECODE_MODE = 1'b0;
   localparam logic CSR_ALPHABET_SIZE = 1'b1;

   // controls broadcast to every cell of the chain
   typedef struct packed {
      logic               load_identity;
      logic               capture_hit;
      logic               commit;
      logic               decode;
      logic [VALUE_W-1:0] key;
      logic [VALUE_W-1:0] front;
   } mtf_cell_ctrl_type;

endpackage

/* rtl/core/move_to_front_codec.sv */
// move_to_front_codec: top level of the move-to-front encoder and decoder
// depends on mtf_pkg, mtf_cell and mtf_reduce
//
// Each word on req_ is a symbol (encode) or a rank (decode); one word comes
// back on rsp_ for each. The table lives in a chain of MAX_ALPHABET cells,
// one entry each; a move to front shifts every cell at or before the match
// back by one place, all together. A word passes through acceptance (with
// the identity reload when first_of_block is set), a compare in every cell,
// one registered group level of the match reduction, and the shift that
// also loads the result register, which waits while a held result blocks it.
// A new word is accepted once the previous one has reached the result
// register, so words never overlap. Reset loads identity order in all cells
// at once; there is no clearing pass. The user must write configuration
// only while idle; the block itself does not enforce it.
module move_to_front_codec #(
   parameter int MAX_ALPHABET = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [mtf_pkg::SIZE_W-1:0]  csr_write_data,
   // input words
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mtf_pkg::VALUE_W-1:0] req_value_in,
   input  logic                        req_first_of_block,
   // result words
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mtf_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                        rsp_out_of_alphabet
);
   import mtf_pkg::*;

   localparam int ENTRY_W = $clog2(MAX_ALPHABET);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HIT   = 2'd1;
   localparam logic [1:0] S_GRP   = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               decode_mode_ff, decode_mode_in;
   logic [SIZE_W-1:0]  alphabet_size_ff, alphabet_size_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_err_ff, rsp_err_in;

   logic                          req_take;
   logic                          commit;
   logic                          item_ok;
   logic [SIZE_W-1:0]             eff_size;
   logic [ENTRY_W-1:0]            result;
   mtf_cell_ctrl_type             ctrl;
   logic [MAX_ALPHABET-1:0]              hit_vec;
   logic [MAX_ALPHABET-1:0][ENTRY_W-1:0] entry_vec;
   logic [MAX_ALPHABET-1:0]              shift_en;
   logic [ENTRY_W-1:0]            sel_entry;
   logic [ENTRY_W-1:0]            rank;
   logic                          found;

   // configuration registers
   always_comb begin
      decode_mode_in   = decode_mode_ff;
      alphabet_size_in = alphabet_size_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DECODE_MODE:   decode_mode_in   = csr_write_data[0];
            CSR_ALPHABET_SIZE: alphabet_size_in = csr_write_data;
            default:           decode_mode_in   = decode_mode_ff;
         endcase
      end
   end

   // handshake and result checks
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign commit    = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);

   assign eff_size = (alphabet_size_ff > SIZE_W'(MAX_ALPHABET)) ?
                     SIZE_W'(MAX_ALPHABET) : alphabet_size_ff;
   assign item_ok  = ({1'b0, key_ff} < eff_size) &&
                     (decode_mode_ff || (SIZE_W'(rank) < eff_size));
   assign result   = decode_mode_ff ? sel_entry : rank;

   // sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               key_in   = req_value_in;
               state_in = S_HIT;
            end
         end
         S_HIT:   state_in = S_GRP;
         S_GRP:   state_in = S_APPLY;
         S_APPLY: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // cell controls
   always_comb begin
      ctrl.load_identity = req_take && req_first_of_block;
      ctrl.capture_hit   = (state_ff == S_HIT);
      ctrl.commit        = commit && item_ok;
      ctrl.decode        = decode_mode_ff;
      ctrl.key           = key_ff;
      ctrl.front         = decode_mode_ff ? VALUE_W'(sel_entry) : key_ff;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = item_ok ? VALUE_W'(result) : '0;
         rsp_err_in   = !item_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         decode_mode_ff   <= 1'b0;
         alphabet_size_ff <= SIZE_W'(256);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         decode_mode_ff   <= decode_mode_in;
         alphabet_size_ff <= alphabet_size_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // chain of table cells, cell zero takes the front symbol
   for (genvar i = 0; i < MAX_ALPHABET; i++) begin : g_cell
      logic [ENTRY_W-1:0] prev_entry;
      if (i == 0) begin : g_head
         assign prev_entry = ENTRY_W'(ctrl.front);
      end else begin : g_link
         assign prev_entry = entry_vec[i-1];
      end
      mtf_cell #(
         .ENTRY_W (ENTRY_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .index      (ENTRY_W'(i)),
         .shift_en   (shift_en[i]),
         .prev_entry (prev_entry),
         .entry      (entry_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // match reduction
   mtf_reduce #(
      .CELLS   (MAX_ALPHABET),
      .ENTRY_W (ENTRY_W)
   ) u_reduce (
      .clock     (clock),
      .capture   (state_ff == S_GRP),
      .hit       (hit_vec),
      .entry     (entry_vec),
      .shift_en  (shift_en),
      .sel_entry (sel_entry),
      .rank      (rank),
      .found     (found)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_value_out       = rsp_value_ff;
   assign rsp_out_of_alphabet = rsp_err_ff;

   // the table is a permutation, so at most one cell matches
   a_single_hit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GRP) |-> $onehot0(hit_vec))
      else $error("more than one cell matched the key");

   // a key below the active size is always present in the table
   a_key_found : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) && ({1'b0, key_ff} < eff_size) |-> found)
      else $error("key below alphabet size not found in table");

   // a finished word always lands in the result register
   a_commit_out : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("committed word missing from result register");

   // the compare step is followed by the group step, in which no word is taken
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HIT) |=> (state_ff == S_GRP) && !req_take)
      else $error("sequencer left the compare step early");

endmodule

/* rtl/core/mtf_cell.sv */
// mtf_cell: one table entry of the move-to-front chain with its match flag
// depends on mtf_pkg
module mtf_cell #(
   parameter int ENTRY_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mtf_pkg::mtf_cell_ctrl_type ctrl,
   input  logic [ENTRY_W-1:0]         index,
   input  logic                       shift_en,
   input  logic [ENTRY_W-1:0]         prev_entry,
   output logic [ENTRY_W-1:0]         entry,
   output logic                       hit
);
   import mtf_pkg::*;

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               hit_ff, hit_in;

   // entry: identity on block start, take neighbor's entry when shifting back
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_identity) begin
         entry_in = index;
      end else if (ctrl.commit && shift_en) begin
         entry_in = prev_entry;
      end
   end

   // match flag: position match when decoding, symbol match when encoding
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture_hit) begin
         if (ctrl.decode) begin
            hit_in = (VALUE_W'(index) == ctrl.key);
         end else begin
            hit_in = (VALUE_W'(entry_ff) == ctrl.key);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= index;
         hit_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

/* rtl/core/mtf_reduce.sv */
// mtf_reduce: two-level reduction over the cell match flags, first level registered;
// gives shift enables, the matched entry and its rank; depends on mtf_pkg
module mtf_reduce #(
   parameter int CELLS   = 256,
   parameter int ENTRY_W = 8
) (
   input  logic                          clock,
   input  logic                          capture,
   input  logic [CELLS-1:0]              hit,
   input  logic [CELLS-1:0][ENTRY_W-1:0] entry,
   output logic [CELLS-1:0]              shift_en,
   output logic [ENTRY_W-1:0]            sel_entry,
   output logic [ENTRY_W-1:0]            rank,
   output logic                          found
);
   import mtf_pkg::*;

   localparam int GROUPS = (CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [GROUPS-1:0]                  grp_any_ff, grp_any_in;
   logic [GROUPS-1:0][ENTRY_W-1:0]     grp_sym_ff, grp_sym_in;
   logic [GROUPS-1:0][GROUP_IDX_W-1:0] grp_lo_ff, grp_lo_in;
   logic [CELLS-1:0]                   suffix_ff, suffix_in;
   logic [GROUPS-1:0]                  higher_any;

   // first level: fold each group of cells (at most one cell matches)
   always_comb begin
      grp_any_in = '0;
      grp_sym_in = '0;
      grp_lo_in  = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CELLS) begin
               if (hit[g * GROUP_SIZE + k]) begin
                  grp_any_in[g] = 1'b1;
                  grp_sym_in[g] = grp_sym_in[g] | entry[g * GROUP_SIZE + k];
                  grp_lo_in[g]  = grp_lo_in[g] | GROUP_IDX_W'(k);
               end
            end
         end
      end
   end

   // in-group suffix: a match at or behind this cell within its group
   always_comb begin
      suffix_in = '0;
      for (int j = 0; j < CELLS; j++) begin
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if ((j / GROUP_SIZE) * GROUP_SIZE + k >= j &&
                (j / GROUP_SIZE) * GROUP_SIZE + k < CELLS) begin
               suffix_in[j] = suffix_in[j] | hit[(j / GROUP_SIZE) * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_any_ff <= grp_any_in;
         grp_sym_ff <= grp_sym_in;
         grp_lo_ff  <= grp_lo_in;
         suffix_ff  <= suffix_in;
      end
   end

   // second level: match in any later group
   always_comb begin
      higher_any = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int h = 0; h < GROUPS; h++) begin
            if (h > g) begin
               higher_any[g] = higher_any[g] | grp_any_ff[h];
            end
         end
      end
   end

   // cells at or before the match move back by one place
   always_comb begin
      for (int j = 0; j < CELLS; j++) begin
         shift_en[j] = suffix_ff[j] | higher_any[j / GROUP_SIZE];
      end
   end

   // second level: matched entry, its position and presence
   always_comb begin
      sel_entry = '0;
      rank      = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sel_entry = sel_entry | grp_sym_ff[g];
         if (grp_any_ff[g]) begin
            rank = rank | ENTRY_W'(g * GROUP_SIZE + int'(grp_lo_ff[g]));
         end
      end
   end

   assign found = |grp_any_ff;

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking testbench of the move-to-front codec, encode and decode
// depends on mtf_pkg and move_to_front_codec; predicts every result word itself
module tb_top;
   import mtf_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               out_of_alphabet;
   } coded_word_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic               csr_index;
   logic [SIZE_W-1:0]  csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value_in;
   logic               req_first_of_block;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_value_out;
   logic               rsp_out_of_alphabet;

   // predictor state: symbol order and the two registers as last written
   logic [VALUE_W-1:0] sym_order [TABLE_DEPTH];
   logic               mode_decode;
   logic [SIZE_W-1:0]  alpha_size;
   coded_word_type     expected_words [$];

   int fail_count = 0;
   int words_checked = 0;
   int words_flagged = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;
   bit send_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   move_to_front_codec #(
      .MAX_ALPHABET(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value_in(req_value_in),
      .req_first_of_block(req_first_of_block),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value_out(rsp_value_out),
      .rsp_out_of_alphabet(rsp_out_of_alphabet)
   );

   // code one accepted word against the predicted symbol order
   function automatic void code_word(input logic [VALUE_W-1:0] v, input logic fob);
      int          lim;
      int          pos;
      int          j;
      bit          hit;
      logic [VALUE_W-1:0] res;
      logic [VALUE_W-1:0] moved;
      coded_word_type cw;
      if (fob) begin
         for (j = 0; j < TABLE_DEPTH; j++) sym_order[j] = j[VALUE_W-1:0];
      end
      lim = (alpha_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(alpha_size);
      hit = 1'b0;
      pos = 0;
      res = '0;
      if (int'(v) < lim) begin
         if (mode_decode) begin
            pos = int'(v);
            res = sym_order[pos];
            hit = 1'b1;
         end else begin
            for (j = 0; j < lim; j++) begin
               if (!hit && sym_order[j] == v) begin
                  pos = j;
                  res = j[VALUE_W-1:0];
                  hit = 1'b1;
               end
            end
         end
      end
      // move to front: entries ahead of the hit slide back one place
      if (hit) begin
         moved = sym_order[pos];
         for (j = pos; j > 0; j--) sym_order[j] = sym_order[j-1];
         sym_order[0] = moved;
      end
      cw.value = hit ? res : '0;
      cw.out_of_alphabet = !hit;
      expected_words = {expected_words, cw};
   endfunction

   // check results, predict accepted words, track register writes
   always @(posedge clock) begin
      coded_word_type cw;
      if (reset) begin
         for (int j = 0; j < TABLE_DEPTH; j++) sym_order[j] = j[VALUE_W-1:0];
         mode_decode = 1'b0;
         alpha_size = SIZE_W'(TABLE_DEPTH);
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with no word outstanding: value_out %0d",
                      rsp_value_out);
               fail_count++;
            end else begin
               cw = expected_words.pop_front();
               words_checked++;
               if (cw.out_of_alphabet) words_flagged++;
               if (rsp_value_out !== cw.value) begin
                  $error("value_out: expected %0d, got %0d", cw.value, rsp_value_out);
                  fail_count++;
               end
               if (rsp_out_of_alphabet !== cw.out_of_alphabet) begin
                  $error("out_of_alphabet: expected %0d, got %0d",
                         cw.out_of_alphabet, rsp_out_of_alphabet);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) code_word(req_value_in, req_first_of_block);
         if (csr_write_enable) begin
            if (csr_index == CSR_DECODE_MODE) mode_decode = csr_write_data[0];
            else alpha_size = csr_write_data;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // result side: long hold-off on request, else random stall bursts
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: too long without any word moving on either channel
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // offer one word, with an optional idle burst first, until accepted
   task automatic send_word(input logic [VALUE_W-1:0] v, input logic fob);
      int gap;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_valid = 1'b0;
         req_value_in = VALUE_W'($urandom_range(0, 255));
         req_first_of_block = 1'($urandom_range(0, 1));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_value_in = v;
      req_first_of_block = fob;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait until every outstanding word has come back
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_writes++;
   endtask

   task automatic set_coding(input logic dec, input logic [SIZE_W-1:0] size);
      wait_drain();
      write_csr(CSR_DECODE_MODE, SIZE_W'(dec));
      write_csr(CSR_ALPHABET_SIZE, size);
   endtask

   // mostly in-alphabet values; decode ranks lean toward the front
   function automatic logic [VALUE_W-1:0] pick_value(input int lim, input bit dec);
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      if (lim == 0 || roll < 12) return VALUE_W'($urandom_range(0, 255));
      top = (lim - 1 < 3) ? lim - 1 : 3;
      if (dec && roll < 55) return VALUE_W'($urandom_range(0, top));
      return VALUE_W'($urandom_range(0, lim - 1));
   endfunction

   // one setting of the registers, then blocks of random content
   task automatic run_coding_phase(input int n_words, input logic dec,
                                   input logic [SIZE_W-1:0] size);
      int   lim;
      int   block_left;
      logic fob;
      set_coding(dec, size);
      lim = (size > TABLE_DEPTH) ? TABLE_DEPTH : int'(size);
      // sometimes keep the old order across the setting change
      block_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
      for (int k = 0; k < n_words; k++) begin
         if (block_left == 0) begin
            block_left = $urandom_range(1, 40);
            fob = 1'b1;
         end else begin
            fob = ($urandom_range(0, 49) == 0);
         end
         send_word(pick_value(lim, dec), fob);
         block_left--;
      end
   endtask

   // encode at the reset settings: value extremes and repeat hits
   task automatic test_encode_extremes();
      send_word(8'd0, 1'b1);
      send_word(8'd255, 1'b0);
      send_word(8'd255, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd128, 1'b1);
   endtask

   task automatic test_decode_extremes();
      set_coding(1'b1, 9'd256);
      send_word(8'd255, 1'b1);
      send_word(8'd0, 1'b0);
      send_word(8'd255, 1'b0);
      send_word(8'd0, 1'b1);
   endtask

   // values at and past a small size; a flagged word still reloads the order
   task automatic test_out_of_range();
      set_coding(1'b0, 9'd5);
      send_word(8'd4, 1'b1);
      send_word(8'd5, 1'b0);
      send_word(8'd255, 1'b0);
      send_word(8'd200, 1'b1);
      send_word(8'd4, 1'b0);
      set_coding(1'b1, 9'd5);
      send_word(8'd5, 1'b0);
   endtask

   // shrink the size inside a block: absent symbol, decoded symbol past size
   task automatic test_shrink_in_block();
      set_coding(1'b0, 9'd256);
      send_word(8'd200, 1'b1);
      set_coding(1'b0, 9'd4);
      send_word(8'd3, 1'b0);
      set_coding(1'b1, 9'd4);
      send_word(8'd0, 1'b0);
   endtask

   // size zero, one and sizes past the table
   task automatic test_size_bounds();
      set_coding(1'b0, 9'd0);
      send_word(8'd0, 1'b1);
      set_coding(1'b0, 9'd257);
      send_word(8'd255, 1'b1);
      set_coding(1'b1, 9'd511);
      send_word(8'd255, 1'b0);
      set_coding(1'b0, 9'd1);
      send_word(8'd0, 1'b1);
      send_word(8'd1, 1'b0);
   endtask

   // receiver holds off while the sender keeps offering, then drain
   task automatic test_backpressure();
      set_coding(1'b0, 9'd256);
      send_gaps = 1'b0;
      rsp_gaps = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      for (int k = 0; k < 16; k++) send_word(pick_value(256, 1'b0), k == 0);
      wait_drain();
   endtask

   task automatic test_random_mix();
      logic [SIZE_W-1:0] size;
      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 9))
            0: size = 9'd1;
            1: size = 9'd2;
            2: size = SIZE_W'($urandom_range(3, 16));
            3, 4: size = SIZE_W'($urandom_range(17, 255));
            5, 6: size = 9'd256;
            7: size = 9'd0;
            8: size = SIZE_W'($urandom_range(257, 511));
            default: size = SIZE_W'($urandom_range(3, 64));
         endcase
         // on each side independently, about a quarter of the phases run without idling
         send_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         run_coding_phase(100, 1'($urandom_range(0, 1)), size);
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_steady_stream();
      send_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_coding_phase(110, 1'b0, 9'd256);
      run_coding_phase(110, 1'b1, SIZE_W'($urandom_range(2, 256)));
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_DECODE_MODE;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_value_in = '0;
      req_first_of_block = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_encode_extremes();
      test_decode_extremes();
      test_out_of_range();
      test_shrink_in_block();
      test_size_bounds();
      test_backpressure();
      test_random_mix();
      test_steady_stream();

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d result words never arrived", expected_words.size());
         fail_count++;
      end
      $display("checked %0d words over %0d register writes, %0d flagged out of alphabet",
               words_checked, csr_writes, words_flagged);
      $display("covered encode and decode, size changes within blocks, long result hold-off");
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
